FILE: sv/aliquot_sum_classifier_assert.svh
// assertion macros for the aliquot sum classifier
// used by asc_seq and asc_dp, no other dependencies
`ifndef ALIQUOT_SUM_CLASSIFIER_ASSERT_SVH
`define ALIQUOT_SUM_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define ASC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/asc_pkg.sv
// shared types, step codes and microprogram rom for the aliquot sum classifier
// no dependencies
package asc_pkg;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_ACCUM,
        ACT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_D_GE_N,
        COND_CNT_MORE,
        COND_OUT_FULL
    } t_cond;

    typedef enum logic [1:0] {
        CLASS_DEFICIENT = 2'd0,
        CLASS_PERFECT   = 2'd1,
        CLASS_ABUNDANT  = 2'd2,
        CLASS_INVALID   = 2'd3
    } t_class;

    localparam int UPC_WIDTH = 3;
    typedef logic [UPC_WIDTH-1:0] t_upc;

    localparam t_upc STEP_WAIT     = 3'd0;
    localparam t_upc STEP_TEST     = 3'd1;
    localparam t_upc STEP_DIV_INIT = 3'd2;
    localparam t_upc STEP_DIV      = 3'd3;
    localparam t_upc STEP_ACCUM    = 3'd4;
    localparam t_upc STEP_EMIT     = 3'd5;
    localparam t_upc STEP_RETURN   = 3'd6;
    localparam t_upc STEP_LAST     = STEP_RETURN;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic d_ge_n;
        logic cnt_last;
        logic out_full;
    } t_status;

    function automatic t_ctrl urom(input t_upc step);
        t_ctrl w;
        case (step)
            STEP_WAIT:     w = '{ACT_LOAD,     COND_NO_INPUT, STEP_WAIT};
            STEP_TEST:     w = '{ACT_NONE,     COND_D_GE_N,   STEP_EMIT};
            STEP_DIV_INIT: w = '{ACT_DIV_INIT, COND_NEVER,    STEP_WAIT};
            STEP_DIV:      w = '{ACT_DIV_STEP, COND_CNT_MORE, STEP_DIV};
            STEP_ACCUM:    w = '{ACT_ACCUM,    COND_ALWAYS,   STEP_TEST};
            STEP_EMIT:     w = '{ACT_EMIT,     COND_OUT_FULL, STEP_EMIT};
            STEP_RETURN:   w = '{ACT_NONE,     COND_ALWAYS,   STEP_WAIT};
            default:       w = '{ACT_NONE,     COND_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/aliquot_sum_classifier.sv
// aliquot sum classifier: sums proper divisors by trial division, microcoded
// one request at a time: the next request is taken in the wait step, once the
// result is loaded and the return step has run; the time per trial divisor is
// set by the one-bit-per-cycle remainder loop
// zero and one skip the divider; reset clears the step counter and output valid
// depends on asc_pkg, asc_seq and asc_dp
module aliquot_sum_classifier #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,   // number
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((NUMBER_WIDTH+2+7)/8)*8-1:0]   o_m_axis_tdata,   // divisor_sum
    output logic [1:0]                            o_m_axis_tuser    // number_class
);
    import asc_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int OW = ((NUMBER_WIDTH + 2 + 7) / 8) * 8;

    t_ctrl         w_ctrl;
    t_status       w_status;
    logic [NW+1:0] w_sum;
    t_class        w_class;

    asc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    asc_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_in_valid     (i_s_axis_tvalid),
        .i_number       (i_s_axis_tdata[NW-1:0]),
        .i_out_ready    (i_m_axis_tready),
        .o_status       (w_status),
        .o_out_valid    (o_m_axis_tvalid),
        .o_divisor_sum  (w_sum),
        .o_number_class (w_class)
    );

    assign o_s_axis_tready = w_ctrl.act == ACT_LOAD;
    assign o_m_axis_tdata  = OW'(w_sum);
    assign o_m_axis_tuser  = w_class;
endmodule

FILE: sv/asc_seq.sv
// microprogram sequencer: step counter, rom lookup and conditional jumps
// depends on asc_pkg and aliquot_sum_classifier_assert.svh
`include "aliquot_sum_classifier_assert.svh"

module asc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  asc_pkg::t_status i_status,
    output asc_pkg::t_ctrl  o_ctrl
);
    import asc_pkg::*;

    t_upc  r_upc;
    t_upc  n_upc;
    t_ctrl w_ctrl;
    logic  w_take;

    assign w_ctrl = urom(r_upc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_NO_INPUT: w_take = !i_status.in_valid;
            COND_D_GE_N:   w_take = i_status.d_ge_n;
            COND_CNT_MORE: w_take = !i_status.cnt_last;
            COND_OUT_FULL: w_take = i_status.out_full;
            default:       w_take = 1'b1;
        endcase
        n_upc = w_take ? w_ctrl.target : r_upc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    `ASC_ASSERT_IMP(a_upc_range, i_clk, i_rst_n, 1'b1, r_upc <= STEP_LAST, "step out of range")
    `ASC_ASSERT_NXT(a_load_to_test, i_clk, i_rst_n,
        r_upc == STEP_WAIT && i_status.in_valid, r_upc == STEP_TEST, "request not started")
endmodule

FILE: sv/asc_dp.sv
// datapath: trial divisor, restoring divider, divisor sum and result register
// depends on asc_pkg and aliquot_sum_classifier_assert.svh
`include "aliquot_sum_classifier_assert.svh"

module asc_dp #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  asc_pkg::t_ctrl          i_ctrl,
    input  logic                    i_in_valid,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  logic                    i_out_ready,
    output asc_pkg::t_status        o_status,
    output logic                    o_out_valid,
    output logic [NUMBER_WIDTH+1:0] o_divisor_sum,
    output asc_pkg::t_class         o_number_class
);
    import asc_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int SW = NW + 2;
    localparam int AW = NW + 3;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_d;
    logic [NW-1:0] r_q;
    logic [NW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_sum;
    logic          r_out_valid;
    logic [SW-1:0] r_out_sum;
    t_class        r_out_class;

    logic [NW:0]   w_trial;
    logic [NW:0]   w_diff;
    logic          w_fits;
    logic [AW-1:0] w_n_ext;
    t_class        w_class;

    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_fits  = w_trial >= {1'b0, r_d};
    assign w_n_ext = AW'(r_n);

    always_comb begin
        if (r_n == '0) begin
            w_class = CLASS_INVALID;
        end else if (r_sum < w_n_ext) begin
            w_class = CLASS_DEFICIENT;
        end else if (r_sum == w_n_ext) begin
            w_class = CLASS_PERFECT;
        end else begin
            w_class = CLASS_ABUNDANT;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            ACT_LOAD: begin
                if (i_in_valid) begin
                    r_n   <= i_number;
                    r_d   <= NW'(1);
                    r_sum <= '0;
                end
            end
            ACT_DIV_INIT: begin
                r_q   <= r_n;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ACT_DIV_STEP: begin
                r_rem <= w_fits ? w_diff[NW-1:0] : w_trial[NW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
                r_cnt <= r_cnt + CW'(1);
            end
            ACT_ACCUM: begin
                if (r_rem == '0) begin
                    r_sum <= r_sum + AW'(r_d);
                end
                r_d <= r_d + NW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.act == ACT_EMIT && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_EMIT && !r_out_valid) begin
            r_out_sum   <= r_sum[SW-1:0];
            r_out_class <= w_class;
        end
    end

    assign o_status.in_valid = i_in_valid;
    assign o_status.d_ge_n   = r_d >= r_n;
    assign o_status.cnt_last = r_cnt == CNT_LAST;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_divisor_sum  = r_out_sum;
    assign o_number_class = r_out_class;

    `ASC_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n,
        i_ctrl.act == ACT_EMIT && !r_out_valid, r_out_valid, "result not loaded")
    `ASC_ASSERT_IMP(a_invalid_zero_sum, i_clk, i_rst_n,
        r_out_valid && r_out_class == CLASS_INVALID, r_out_sum == '0, "invalid with nonzero sum")
    `ASC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n,
        i_ctrl.act == ACT_DIV_STEP, r_cnt <= CNT_LAST, "divider step count overrun")
endmodule
